@@ src/fcsl_pkg.sv @@
`timescale 1ns / 1ps
package fcsl_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int DUTY_BITS_DEF = 12;

	localparam int MW = 34;
	localparam int PW = 2 * MW;
	localparam int ZW = 26;
	localparam int DNW = 52;
	localparam int DDW = 32;
	localparam int DCW = $clog2(DNW);

	localparam logic signed [MW-1:0] GAIN_Q30 = 34'sd652032874;
	localparam logic signed [MW-1:0] INV_SQRT3_Q16 = 34'sd37837;
	localparam logic signed [MW-1:0] HALF_SQRT3_Q16 = 34'sd56756;

	typedef enum logic [2:0] {
		REG_SPEED_TARGET = 3'd0,
		REG_CURRENT_KP = 3'd1,
		REG_CURRENT_KI_STEP = 3'd2,
		REG_SPEED_KP = 3'd3,
		REG_SPEED_KI_STEP = 3'd4,
		REG_VOLTAGE_LIMIT = 3'd5,
		REG_RATED_CURRENT = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic start;
		logic vectoring;
		logic [15:0] angle;
		logic signed [15:0] a;
		logic signed [15:0] b;
	} cordic_req_t;

	typedef struct packed {
		logic done;
		logic signed [MW-1:0] x;
		logic signed [MW-1:0] y;
	} cordic_rsp_t;

	typedef struct packed {
		logic start;
		logic signed [DNW-1:0] num;
		logic [DDW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic signed [DNW-1:0] quot;
	} div_rsp_t;

	function automatic logic signed [ZW-1:0] atan_q(input logic [4:0] i);
		logic signed [ZW-1:0] r;
		case (i)
			5'd0: r = 26'sd2097152;
			5'd1: r = 26'sd1238021;
			5'd2: r = 26'sd654136;
			5'd3: r = 26'sd332050;
			5'd4: r = 26'sd166669;
			5'd5: r = 26'sd83416;
			5'd6: r = 26'sd41718;
			5'd7: r = 26'sd20860;
			5'd8: r = 26'sd10430;
			5'd9: r = 26'sd5215;
			5'd10: r = 26'sd2608;
			5'd11: r = 26'sd1304;
			5'd12: r = 26'sd652;
			5'd13: r = 26'sd326;
			5'd14: r = 26'sd163;
			5'd15: r = 26'sd81;
			5'd16: r = 26'sd41;
			5'd17: r = 26'sd20;
			5'd18: r = 26'sd10;
			5'd19: r = 26'sd5;
			5'd20: r = 26'sd3;
			5'd21: r = 26'sd1;
			5'd22: r = 26'sd1;
			default: r = 26'sd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [PW-1:0] clamp_s(input logic signed [PW-1:0] v,
		input logic signed [PW-1:0] lo, input logic signed [PW-1:0] hi);
		logic signed [PW-1:0] r;
		if (v > hi)
			r = hi;
		else if (v < lo)
			r = lo;
		else
			r = v;
		return r;
	endfunction

endpackage

@@ src/fcsl_cordic.sv @@
`timescale 1ns / 1ps
module fcsl_cordic #(
	parameter int STEPS = fcsl_pkg::CORDIC_STEPS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fcsl_pkg::cordic_req_t req,
	output fcsl_pkg::cordic_rsp_t rsp
);
	import fcsl_pkg::*;

	logic busy_q, done_q, vec_q, flip_q;
	logic [4:0] step_q;
	logic signed [MW-1:0] x_q, y_q, xs, ys;
	logic signed [ZW-1:0] z_q, z0, atn;
	logic ccw;
	logic signed [16:0] a_ext, a_abs;

	always_comb begin
		xs = x_q >>> step_q;
		ys = y_q >>> step_q;
		atn = atan_q(step_q);
		ccw = vec_q ? y_q[MW-1] : !z_q[ZW-1];
		z0 = ZW'($signed({req.angle, 8'b0}));
		a_ext = 17'(req.a);
		a_abs = a_ext[16] ? -a_ext : a_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			vec_q <= 1'b0;
			flip_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				vec_q <= req.vectoring;
				if (req.vectoring) begin
					x_q <= MW'(a_abs) <<< 12;
					y_q <= MW'(req.b) <<< 12;
					z_q <= '0;
					flip_q <= 1'b0;
				end else begin
					x_q <= GAIN_Q30;
					y_q <= '0;
					if (z0 > 26'sd4194304) begin
						z_q <= z0 - 26'sd8388608;
						flip_q <= 1'b1;
					end else if (z0 < -26'sd4194304) begin
						z_q <= z0 + 26'sd8388608;
						flip_q <= 1'b1;
					end else begin
						z_q <= z0;
						flip_q <= 1'b0;
					end
				end
			end else if (busy_q) begin
				if (ccw) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - atn;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + atn;
				end
				step_q <= step_q + 5'd1;
				if (step_q == 5'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.x = flip_q ? -x_q : x_q;
	assign rsp.y = flip_q ? -y_q : y_q;

endmodule

@@ src/fcsl_div.sv @@
`timescale 1ns / 1ps
module fcsl_div (
	input  logic              clk,
	input  logic              arst_n,
	input  fcsl_pkg::div_req_t req,
	output fcsl_pkg::div_rsp_t rsp
);
	import fcsl_pkg::*;

	logic busy_q, done_q, neg_q;
	logic [DCW-1:0] cnt_q;
	logic [DNW-1:0] quo_q, num_abs;
	logic [DDW-1:0] rem_q, den_q;
	logic [DDW:0] rem_sh, rem_nx;
	logic ge;

	always_comb begin
		num_abs = req.num[DNW-1] ? DNW'(-req.num) : DNW'(req.num);
		rem_sh = {rem_q, quo_q[DNW-1]};
		ge = rem_sh >= {1'b0, den_q};
		rem_nx = ge ? rem_sh - {1'b0, den_q} : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
				quo_q <= num_abs;
				rem_q <= '0;
				den_q <= req.den;
				neg_q <= req.num[DNW-1];
			end else if (busy_q) begin
				quo_q <= {quo_q[DNW-2:0], ge};
				rem_q <= rem_nx[DDW-1:0];
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DCW'(DNW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

@@ src/foc_current_speed_loop.sv @@
`timescale 1ns / 1ps
// Speed word: steps through ST_SPD_I and ST_SPD_P back to ready, no output word.
// Current word: uses the iterative CORDIC and the bit-serial divider, with two
// more divider runs when the voltage vector is scaled.
// One word in flight at a time; a finished word waits in the output register.
// Reset (arst_n low) restores the default gains and clears all integrators.
module foc_current_speed_loop #(
	parameter int CORDIC_STEPS = fcsl_pkg::CORDIC_STEPS_DEF,
	parameter int DUTY_BITS = fcsl_pkg::DUTY_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // phase_a_current, phase_b_current, electrical_angle, measured_speed
	input  logic        s_tuser,  // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // duty_u, duty_v, duty_w, d_current, q_current
	output logic        m_tuser,  // circle_limited
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import fcsl_pkg::*;

	localparam logic signed [PW-1:0] HALF = PW'(1) <<< (DUTY_BITS - 1);

	typedef enum logic [4:0] {
		ST_IDLE, ST_SPD_I, ST_SPD_P, ST_BETA, ST_ROT_WAIT, ST_D1, ST_D2, ST_Q1, ST_Q2,
		ST_PID_I, ST_PID_P, ST_PIQ_I, ST_PIQ_P, ST_VEC_START, ST_VEC_WAIT, ST_MAG,
		ST_CHECK, ST_CIRC_MUL, ST_DIV_WAIT, ST_IP1, ST_IP2, ST_IP3, ST_IP4,
		ST_CLARKE, ST_DUTY_START, ST_DONE
	} state_t;

	typedef enum logic [2:0] {SEL_VD, SEL_VQ, SEL_U, SEL_V, SEL_W} sel_t;

	state_t state_q;
	sel_t sel_q;

	logic signed [15:0] speed_target_q;
	logic [15:0] current_kp_q, current_ki_q, speed_kp_q, speed_ki_q;
	logic [14:0] vlim_q, rated_q;

	logic signed [15:0] ia_q, ib_q, id_q, iq_q, vd_q, vq_q, tref_q;
	logic [15:0] ang_q;
	logic signed [16:0] err_q;
	logic signed [17:0] beta_q, va_q, vb_q;
	logic signed [MW-1:0] c_q, s_q, magx_q, mag_q;
	logic signed [PW-1:0] acc_q;
	logic signed [23:0] dint_q, qint_q;
	logic signed [31:0] sint_q;
	logic signed [35:0] vu_q, vv_q, vw_q, vsel;
	logic [12:0] duty_u_q, duty_v_q, duty_w_q, duty_nx;
	logic lim_q;
	logic cor_start_q, cor_vec_q, div_start_q;
	logic signed [DNW-1:0] div_num_q;
	logic [DDW-1:0] div_den_q;
	logic m_valid_q, m_user_q;
	logic [71:0] m_data_q;

	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] mul_p, rl_w, vl_w, vl256, vl4096, e_w, dsum;
	logic signed [17:0] ab_sum;

	cordic_req_t cor_req;
	cordic_rsp_t cor_rsp;
	div_req_t div_req;
	div_rsp_t div_rsp;

	fcsl_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .req(cor_req), .rsp(cor_rsp)
	);

	fcsl_div u_div (
		.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp)
	);

	assign cor_req.start = cor_start_q;
	assign cor_req.vectoring = cor_vec_q;
	assign cor_req.angle = ang_q;
	assign cor_req.a = vd_q;
	assign cor_req.b = vq_q;
	assign div_req.start = div_start_q;
	assign div_req.num = div_num_q;
	assign div_req.den = div_den_q;

	always_comb begin
		ab_sum = 18'(ia_q) + (18'(ib_q) <<< 1);
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SPD_I: begin mul_a = MW'(speed_ki_q); mul_b = MW'(err_q); end
			ST_SPD_P: begin mul_a = MW'(speed_kp_q); mul_b = MW'(err_q); end
			ST_BETA: begin mul_a = MW'(ab_sum); mul_b = INV_SQRT3_Q16; end
			ST_D1: begin mul_a = c_q; mul_b = MW'(ia_q); end
			ST_D2: begin mul_a = s_q; mul_b = MW'(beta_q); end
			ST_Q1: begin mul_a = c_q; mul_b = MW'(beta_q); end
			ST_Q2: begin mul_a = s_q; mul_b = MW'(ia_q); end
			ST_PID_I, ST_PIQ_I: begin mul_a = MW'(current_ki_q); mul_b = MW'(err_q); end
			ST_PID_P, ST_PIQ_P: begin mul_a = MW'(current_kp_q); mul_b = MW'(err_q); end
			ST_MAG: begin mul_a = magx_q; mul_b = GAIN_Q30; end
			ST_CIRC_MUL: begin
				mul_a = (sel_q == SEL_VD) ? MW'(vd_q) : MW'(vq_q);
				mul_b = MW'(vlim_q);
			end
			ST_IP1: begin mul_a = c_q; mul_b = MW'(vd_q); end
			ST_IP2: begin mul_a = s_q; mul_b = MW'(vq_q); end
			ST_IP3: begin mul_a = s_q; mul_b = MW'(vd_q); end
			ST_IP4: begin mul_a = c_q; mul_b = MW'(vq_q); end
			ST_CLARKE: begin mul_a = HALF_SQRT3_Q16; mul_b = MW'(vb_q); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
		mul_p = mul_a * mul_b;
		rl_w = PW'(rated_q) <<< 12;
		vl_w = PW'(vlim_q);
		vl256 = vl_w <<< 8;
		vl4096 = vl_w <<< 12;
		case (sel_q)
			SEL_U: vsel = vu_q;
			SEL_V: vsel = vv_q;
			default: vsel = vw_q;
		endcase
		e_w = PW'(div_rsp.quot);
		dsum = clamp_s(HALF + e_w, '0, HALF <<< 1);
		duty_nx = dsum[12:0];
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata = m_data_q;
	assign m_tuser = m_user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q <= SEL_VD;
			speed_target_q <= '0;
			current_kp_q <= 16'd9651;
			current_ki_q <= 16'd1351;
			speed_kp_q <= 16'd31215;
			speed_ki_q <= 16'd474;
			vlim_q <= 15'd15104;
			rated_q <= 15'd4096;
			dint_q <= '0;
			qint_q <= '0;
			sint_q <= '0;
			tref_q <= '0;
			cor_start_q <= 1'b0;
			cor_vec_q <= 1'b0;
			div_start_q <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (m_valid_q && m_tready && state_q != ST_DONE)
				m_valid_q <= 1'b0;
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_index))
					REG_SPEED_TARGET: speed_target_q <= cfg_data;
					REG_CURRENT_KP: current_kp_q <= cfg_data;
					REG_CURRENT_KI_STEP: current_ki_q <= cfg_data;
					REG_SPEED_KP: speed_kp_q <= cfg_data;
					REG_SPEED_KI_STEP: speed_ki_q <= cfg_data;
					REG_VOLTAGE_LIMIT: vlim_q <= cfg_data[14:0];
					REG_RATED_CURRENT: rated_q <= cfg_data[14:0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						ia_q <= s_tdata[15:0];
						ib_q <= s_tdata[31:16];
						ang_q <= s_tdata[47:32];
						err_q <= 17'(speed_target_q) - 17'($signed(s_tdata[63:48]));
						if (s_tuser) begin
							state_q <= ST_SPD_I;
						end else begin
							cor_start_q <= 1'b1;
							cor_vec_q <= 1'b0;
							state_q <= ST_BETA;
						end
					end
				end
				ST_SPD_I: begin
					sint_q <= 32'(clamp_s(PW'(sint_q) + mul_p, -rl_w, rl_w));
					state_q <= ST_SPD_P;
				end
				ST_SPD_P: begin
					tref_q <= 16'(clamp_s(clamp_s((mul_p <<< 8) + PW'(sint_q), -rl_w, rl_w)
						>>> 12, '0, PW'(rated_q)));
					state_q <= ST_IDLE;
				end
				ST_BETA: begin
					cor_start_q <= 1'b0;
					beta_q <= 18'(mul_p >>> 16);
					state_q <= ST_ROT_WAIT;
				end
				ST_ROT_WAIT: begin
					if (cor_rsp.done) begin
						c_q <= cor_rsp.x;
						s_q <= cor_rsp.y;
						state_q <= ST_D1;
					end
				end
				ST_D1: begin
					acc_q <= mul_p;
					state_q <= ST_D2;
				end
				ST_D2: begin
					id_q <= 16'(clamp_s((acc_q + mul_p) >>> 30, -PW'(32768), PW'(32767)));
					state_q <= ST_Q1;
				end
				ST_Q1: begin
					acc_q <= mul_p;
					state_q <= ST_Q2;
				end
				ST_Q2: begin
					iq_q <= 16'(clamp_s((acc_q - mul_p) >>> 30, -PW'(32768), PW'(32767)));
					err_q <= 17'sd0 - 17'(id_q);
					state_q <= ST_PID_I;
				end
				ST_PID_I: begin
					dint_q <= 24'(clamp_s(PW'(dint_q) + (mul_p >>> 3), -vl256, vl256));
					state_q <= ST_PID_P;
				end
				ST_PID_P: begin
					vd_q <= 16'(clamp_s((mul_p + (PW'(dint_q) <<< 3)) >>> 11, -vl_w, vl_w));
					err_q <= 17'(tref_q) - 17'(iq_q);
					state_q <= ST_PIQ_I;
				end
				ST_PIQ_I: begin
					qint_q <= 24'(clamp_s(PW'(qint_q) + (mul_p >>> 3), -vl256, vl256));
					state_q <= ST_PIQ_P;
				end
				ST_PIQ_P: begin
					vq_q <= 16'(clamp_s((mul_p + (PW'(qint_q) <<< 3)) >>> 11, -vl_w, vl_w));
					state_q <= ST_VEC_START;
				end
				ST_VEC_START: begin
					cor_start_q <= 1'b1;
					cor_vec_q <= 1'b1;
					state_q <= ST_VEC_WAIT;
				end
				ST_VEC_WAIT: begin
					cor_start_q <= 1'b0;
					if (cor_rsp.done) begin
						magx_q <= cor_rsp.x;
						state_q <= ST_MAG;
					end
				end
				ST_MAG: begin
					mag_q <= MW'(mul_p >>> 30);
					lim_q <= 1'b0;
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (PW'(mag_q) > vl4096) begin
						lim_q <= 1'b1;
						sel_q <= SEL_VD;
						state_q <= ST_CIRC_MUL;
					end else begin
						state_q <= ST_IP1;
					end
				end
				ST_CIRC_MUL: begin
					div_num_q <= DNW'(mul_p <<< 12);
					div_den_q <= DDW'(mag_q);
					div_start_q <= 1'b1;
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					div_start_q <= 1'b0;
					if (div_rsp.done) begin
						case (sel_q)
							SEL_VD: begin
								vd_q <= 16'(div_rsp.quot);
								sel_q <= SEL_VQ;
								state_q <= ST_CIRC_MUL;
							end
							SEL_VQ: begin
								vq_q <= 16'(div_rsp.quot);
								state_q <= ST_IP1;
							end
							SEL_U: begin
								duty_u_q <= duty_nx;
								sel_q <= SEL_V;
								state_q <= ST_DUTY_START;
							end
							SEL_V: begin
								duty_v_q <= duty_nx;
								sel_q <= SEL_W;
								state_q <= ST_DUTY_START;
							end
							default: begin
								duty_w_q <= duty_nx;
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_IP1: begin
					acc_q <= mul_p;
					state_q <= ST_IP2;
				end
				ST_IP2: begin
					va_q <= 18'((acc_q - mul_p) >>> 30);
					state_q <= ST_IP3;
				end
				ST_IP3: begin
					acc_q <= mul_p;
					state_q <= ST_IP4;
				end
				ST_IP4: begin
					vb_q <= 18'((acc_q + mul_p) >>> 30);
					state_q <= ST_CLARKE;
				end
				ST_CLARKE: begin
					vu_q <= 36'(va_q) <<< 16;
					vv_q <= -(36'(va_q) <<< 15) + 36'(mul_p);
					vw_q <= -(36'(va_q) <<< 15) - 36'(mul_p);
					sel_q <= SEL_U;
					state_q <= ST_DUTY_START;
				end
				ST_DUTY_START: begin
					if (vlim_q == '0) begin
						case (sel_q)
							SEL_U: begin
								duty_u_q <= HALF[12:0];
								sel_q <= SEL_V;
							end
							SEL_V: begin
								duty_v_q <= HALF[12:0];
								sel_q <= SEL_W;
							end
							default: begin
								duty_w_q <= HALF[12:0];
								state_q <= ST_DONE;
							end
						endcase
					end else begin
						div_num_q <= DNW'(vsel) <<< (DUTY_BITS - 1);
						div_den_q <= DDW'({vlim_q, 16'b0});
						div_start_q <= 1'b1;
						state_q <= ST_DIV_WAIT;
					end
				end
				ST_DONE: begin
					if (!m_valid_q || m_tready) begin
						m_data_q <= {1'b0, iq_q, id_q, duty_w_q, duty_v_q, duty_u_q};
						m_user_q <= lim_q;
						m_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
	import fcsl_pkg::*;

	localparam int STEPS = CORDIC_STEPS_DEF;
	localparam longint HALF_DUTY = 1 << (DUTY_BITS_DEF - 1);
	localparam longint GAIN = 652032874;
	localparam int DRAIN_CYCLES = 500;
	localparam int HOLD_CYCLES = 2500;
	localparam int IDLE_LIMIT = 20000;
	localparam logic [2:0] REG_UNUSED = 3'd7;

	localparam longint ATAN_Q24 [24] = '{2097152, 1238021, 654136, 332050, 166669, 83416,
		41718, 20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};

	typedef struct {
		bit action;
		logic signed [15:0] ia;
		logic signed [15:0] ib;
		logic [15:0] angle;
		logic signed [15:0] speed;
	} sample_t;

	typedef struct {
		logic [12:0] du;
		logic [12:0] dv;
		logic [12:0] dw;
		logic signed [15:0] id;
		logic signed [15:0] iq;
		logic lim;
	} drive_t;

	typedef struct {
		sample_t s;
		bit known;
		drive_t r;
	} row_t;

	logic clk, arst_n;
	logic s_tvalid, s_tready, s_tuser;
	logic [63:0] s_tdata;
	logic m_tvalid, m_tready, m_tuser;
	logic [71:0] m_tdata;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;

	foc_current_speed_loop dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	longint spd_ref, cur_kp, cur_ki, spd_kp, spd_ki, v_lim, i_rated;
	longint d_int, q_int, spd_int, iq_ref;
	drive_t pending_drives[$];
	int errors = 0;
	int idle_cycles = 0;
	int rx_mode = 0;
	bit hold_go = 0;
	int burst_left = 0;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic longint clip(longint v, longint lo, longint hi);
		return v > hi ? hi : (v < lo ? lo : v);
	endfunction

	function automatic void rotor_sincos(logic [15:0] ang, output longint c, output longint s);
		longint z, x, y, t;
		bit flip;
		z = longint'(ang) << 8;
		x = GAIN;
		y = 0;
		flip = 0;
		if (z >= 8388608)
			z -= 16777216;
		if (z > 4194304) begin
			z -= 8388608;
			flip = 1;
		end else if (z < -4194304) begin
			z += 8388608;
			flip = 1;
		end
		for (int i = 0; i < STEPS && i < 24; i++) begin
			if (z >= 0) begin
				t = x - (y >>> i);
				y = y + (x >>> i);
				z -= ATAN_Q24[i];
			end else begin
				t = x + (y >>> i);
				y = y - (x >>> i);
				z += ATAN_Q24[i];
			end
			x = t;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic longint vector_mag(longint a, longint b);
		longint x, y, t;
		x = (a < 0 ? -a : a) * 4096;
		y = b * 4096;
		for (int i = 0; i < STEPS && i < 24; i++) begin
			if (y >= 0) begin
				t = x + (y >>> i);
				y = y - (x >>> i);
			end else begin
				t = x - (y >>> i);
				y = y + (x >>> i);
			end
			x = t;
		end
		return (x * GAIN) >>> 30;
	endfunction

	function automatic longint axis_pi(inout longint integ, input longint e);
		integ = clip(integ + ((cur_ki * e) >>> 3), -v_lim * 256, v_lim * 256);
		return clip((cur_kp * e + integ * 8) >>> 11, -v_lim, v_lim);
	endfunction

	function automatic logic [12:0] phase_duty(longint v16);
		longint d;
		d = HALF_DUTY;
		if (v_lim != 0)
			d = HALF_DUTY + (v16 * HALF_DUTY) / (v_lim * 65536);
		return 13'(clip(d, 0, 2 * HALF_DUTY));
	endfunction

	function automatic bit foc_update(sample_t w, output drive_t r);
		longint al, be, c, s, id, iq, vd, vq, va, vb, mag, rl, e, o;
		r = '{default: '0};
		if (w.action) begin
			rl = i_rated * 4096;
			e = spd_ref - longint'(w.speed);
			spd_int = clip(spd_int + spd_ki * e, -rl, rl);
			o = clip(spd_kp * e * 256 + spd_int, -rl, rl);
			iq_ref = clip(o >>> 12, 0, i_rated);
			return 0;
		end
		al = w.ia;
		be = ((longint'(w.ia) + 2 * longint'(w.ib)) * 37837) >>> 16;
		rotor_sincos(w.angle, c, s);
		id = clip((c * al + s * be) >>> 30, -32768, 32767);
		iq = clip((c * be - s * al) >>> 30, -32768, 32767);
		vd = axis_pi(d_int, -id);
		vq = axis_pi(q_int, iq_ref - iq);
		mag = vector_mag(vd, vq);
		r.lim = 0;
		if (mag > v_lim * 4096) begin
			vd = vd * v_lim * 4096 / mag;
			vq = vq * v_lim * 4096 / mag;
			r.lim = 1;
		end
		va = (c * vd - s * vq) >>> 30;
		vb = (s * vd + c * vq) >>> 30;
		r.du = phase_duty(va * 65536);
		r.dv = phase_duty(-va * 32768 + 56756 * vb);
		r.dw = phase_duty(-va * 32768 - 56756 * vb);
		r.id = 16'(id);
		r.iq = 16'(iq);
		return 1;
	endfunction

	task automatic report(string what);
		$display("mismatch @%0t: %s", $realtime, what);
		errors++;
	endtask

	// accept one word, queue the drive it should yield (a speed word yields none)
	task automatic send_word(sample_t w, bit known, drive_t kr);
		drive_t r;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (!hold_go && $urandom_range(0, 3) != 0) begin
				s_tvalid = 0;
				repeat ($urandom_range(1, 40)) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid = 1;
		s_tuser = w.action;
		s_tdata = {w.speed, w.angle, w.ib, w.ia};
		do @(posedge clk); while (!s_tready);
		if (foc_update(w, r))
			pending_drives.push_back(known ? kr : r);
		@(negedge clk);
		s_tvalid = 0;
	endtask

	task automatic wait_idle();
		while (pending_drives.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 0;
		case (idx)
			REG_SPEED_TARGET: spd_ref = longint'($signed(val));
			REG_CURRENT_KP: cur_kp = val;
			REG_CURRENT_KI_STEP: cur_ki = val;
			REG_SPEED_KP: spd_kp = val;
			REG_SPEED_KI_STEP: spd_ki = val;
			REG_VOLTAGE_LIMIT: v_lim = val[14:0];
			REG_RATED_CURRENT: i_rated = val[14:0];
			default: ;
		endcase
	endtask

	task automatic program_all(logic [15:0] tgt, logic [15:0] ckp, logic [15:0] cki,
		logic [15:0] skp, logic [15:0] ski, logic [15:0] vl, logic [15:0] rc);
		wait_idle();
		write_reg(REG_SPEED_TARGET, tgt);
		write_reg(REG_CURRENT_KP, ckp);
		write_reg(REG_CURRENT_KI_STEP, cki);
		write_reg(REG_SPEED_KP, skp);
		write_reg(REG_SPEED_KI_STEP, ski);
		write_reg(REG_VOLTAGE_LIMIT, vl);
		write_reg(REG_RATED_CURRENT, rc);
	endtask

	function automatic sample_t rand_sample();
		sample_t w;
		w.action = ($urandom_range(0, 9) < 3);
		w.angle = 16'($urandom);
		if ($urandom_range(0, 2) == 0) begin
			w.ia = 16'($urandom);
			w.ib = 16'($urandom);
		end else begin
			w.ia = 16'($signed($urandom_range(0, 8000)) - 4000);
			w.ib = 16'($signed($urandom_range(0, 8000)) - 4000);
		end
		if ($urandom_range(0, 2) == 0)
			w.speed = 16'($urandom);
		else
			w.speed = 16'(clip(spd_ref + $signed($urandom_range(0, 600)) - 300,
				-32768, 32767));
		return w;
	endfunction

	task automatic random_phase(int n, int mode);
		rx_mode = mode;
		for (int k = 0; k < n; k++)
			send_word(rand_sample(), 0, '{default: '0});
	endtask

	row_t rows[$];

	always @(posedge clk) begin
		drive_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_drives.size() == 0) begin
				report("drive word with none expected");
			end else begin
				e = pending_drives.pop_front();
				if (m_tdata[12:0] !== e.du)
					report($sformatf("duty_u %0d exp %0d", m_tdata[12:0], e.du));
				if (m_tdata[25:13] !== e.dv)
					report($sformatf("duty_v %0d exp %0d", m_tdata[25:13], e.dv));
				if (m_tdata[38:26] !== e.dw)
					report($sformatf("duty_w %0d exp %0d", m_tdata[38:26], e.dw));
				if (m_tdata[54:39] !== e.id)
					report($sformatf("d_current %0d exp %0d",
						$signed(m_tdata[54:39]), e.id));
				if (m_tdata[70:55] !== e.iq)
					report($sformatf("q_current %0d exp %0d",
						$signed(m_tdata[70:55]), e.iq));
				if (m_tuser !== e.lim)
					report($sformatf("circle_limited %0b exp %0b", m_tuser, e.lim));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		m_tready = 0;
		forever begin
			@(negedge clk);
			if (hold_go) begin
				m_tready = 0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_go = 0;
			end else begin
				case (rx_mode)
					0: m_tready = 1;
					1: m_tready = $urandom_range(0, 1);
					default: m_tready = ($urandom_range(0, 5) == 0);
				endcase
			end
		end
	end

	initial begin
		drive_t half_zero;
		arst_n = 0;
		s_tvalid = 0;
		s_tuser = 0;
		s_tdata = '0;
		cfg_we = 0;
		cfg_index = REG_SPEED_TARGET;
		cfg_data = '0;
		spd_ref = 0; cur_kp = 9651; cur_ki = 1351; spd_kp = 31215; spd_ki = 474;
		v_lim = 15104; i_rated = 4096;
		d_int = 0; q_int = 0; spd_int = 0; iq_ref = 0;
		half_zero = '{du: 13'd2048, dv: 13'd2048, dw: 13'd2048, id: 0, iq: 0, lim: 0};

		rows.push_back('{'{0, 16'sd0, 16'sd0, 16'd0, 16'sd0}, 1, half_zero});
		rows.push_back('{'{0, 16'sh7fff, 16'sd0, 16'd0, 16'sd0}, 0, half_zero});
		rows.push_back('{'{0, -16'sd32768, 16'sd0, 16'd16384, 16'sd0}, 0, half_zero});
		rows.push_back('{'{0, 16'sd0, 16'sh7fff, 16'd32768, 16'sd0}, 0, half_zero});
		rows.push_back('{'{0, 16'sd0, -16'sd32768, 16'd49152, 16'sd0}, 0, half_zero});
		rows.push_back('{'{0, 16'sh7fff, 16'sh7fff, 16'hffff, 16'sd0}, 0, half_zero});
		rows.push_back('{'{0, -16'sd32768, -16'sd32768, 16'd8192, 16'sd0}, 0, half_zero});
		rows.push_back('{'{1, 16'sd0, 16'sd0, 16'd0, -16'sd32768}, 0, half_zero});
		rows.push_back('{'{0, 16'sd1000, -16'sd500, 16'd12000, 16'sd0}, 0, half_zero});
		rows.push_back('{'{1, 16'sh7fff, 16'sd0, 16'd0, 16'sh7fff}, 0, half_zero});
		rows.push_back('{'{0, 16'sd1000, -16'sd500, 16'd12000, 16'sd0}, 0, half_zero});
		rows.push_back('{'{1, 16'sd0, 16'sd0, 16'd0, -16'sd1200}, 0, half_zero});
		rows.push_back('{'{0, -16'sd300, 16'sd2500, 16'd40000, 16'sh7fff}, 0, half_zero});
		rows.push_back('{'{0, 16'sd4096, 16'sd0, 16'd24576, 16'sd0}, 0, half_zero});
		rows.push_back('{'{0, 16'sd0, 16'sd0, 16'd0, 16'sd0}, 0, half_zero});

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		rx_mode = 0;
		foreach (rows[k])
			send_word(rows[k].s, rows[k].known, rows[k].r);

		random_phase(200, 1);
		program_all(16'h7fff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'd1, 16'h7fff);
		write_reg(REG_UNUSED, 16'hffff);
		random_phase(150, 0);
		program_all(16'h8000, 16'd0, 16'd0, 16'd0, 16'd0, 16'h7fff, 16'd0);
		random_phase(150, 2);
		program_all(16'd1500, 16'd20000, 16'd5000, 16'd40000, 16'd3000, 16'd0, 16'd8000);
		random_phase(150, 1);
		program_all(16'd3000, 16'd9651, 16'd1351, 16'd31215, 16'd474, 16'd15104, 16'd4096);
		hold_go = 1;
		random_phase(150, 1);
		// lower the limit under wound-up integrators
		program_all(16'd3000, 16'd9651, 16'd60000, 16'd31215, 16'd474, 16'd200, 16'd4096);
		random_phase(150, 0);
		for (int p = 0; p < 3; p++) begin
			program_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), 16'($urandom_range(1, 32767)), 16'($urandom_range(0, 32767)));
			random_phase(100, p % 3);
		end

		rx_mode = 1;
		wait_idle();
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
